// ----- hw/rtl/projection_text_box_segmenter_macros.svh -----
// Assertion macros shared by the text box segmenter modules.
// Each expects signals named clk and arst_n in the including module.
`ifndef PROJECTION_TEXT_BOX_SEGMENTER_MACROS_SVH
`define PROJECTION_TEXT_BOX_SEGMENTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PTS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/pts_pkg.sv -----
// Package for the projection text box segmenter: widths, defaults, register codes
// and the box types passed between the controller and the output stage. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pts_pkg;

	localparam int MAX_WIDTH_DEF  = 128;
	localparam int MAX_HEIGHT_DEF = 256;

	localparam int IMG_WIDTH_W  = 8;
	localparam int IMG_HEIGHT_W = 9;
	localparam int BOX_COL_W    = 7;
	localparam int BOX_ROW_W    = 8;
	localparam int APB_ADDR_W   = 3;
	localparam int APB_DATA_W   = 32;

	localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RST  = 8'd128;
	localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RST = 9'd256;

	// register index, taken from paddr[2]
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		logic [BOX_COL_W-1:0] left;
		logic [BOX_COL_W-1:0] right;
		logic [BOX_ROW_W-1:0] top;
		logic [BOX_ROW_W-1:0] bottom;
	} box_t;

	typedef struct packed {
		logic push;
		logic flush;
		box_t box;
	} box_cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/pts_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module pts_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/pts_box_out.sv -----
// Box output stage: one pending box and one output register, so the last box of a
// band can be marked. Depends on pts_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "projection_text_box_segmenter_macros.svh"
module pts_box_out (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pts_pkg::box_cmd_t             cmd,
	output logic                               cmd_ready,
	output logic                               box_valid,
	input  wire logic                          box_ready,
	output logic      [pts_pkg::BOX_COL_W-1:0] box_left,
	output logic      [pts_pkg::BOX_COL_W-1:0] box_right,
	output logic      [pts_pkg::BOX_ROW_W-1:0] box_top,
	output logic      [pts_pkg::BOX_ROW_W-1:0] box_bottom,
	output logic                               last_box
);
	import pts_pkg::*;

	logic pend_valid_q;
	box_t pend_q;
	logic out_valid_q;
	box_t out_q;
	logic out_last_q;
	logic out_free;
	logic load_out;

	assign out_free  = !out_valid_q || box_ready;
	assign cmd_ready = !pend_valid_q || out_free;
	assign load_out  = cmd_ready && pend_valid_q && (cmd.push || cmd.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (box_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.push && cmd_ready) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush && cmd_ready) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q      <= pend_q;
			out_last_q <= cmd.flush;
		end
		if (cmd.push && cmd_ready) begin
			pend_q <= cmd.box;
		end
	end

	assign box_valid  = out_valid_q;
	assign box_left   = out_q.left;
	assign box_right  = out_q.right;
	assign box_top    = out_q.top;
	assign box_bottom = out_q.bottom;
	assign last_box   = out_last_q;

	`PTS_ASSERT_NXT(a_push_keeps_pend, cmd.push && cmd_ready, pend_valid_q,
		"pushed box not held as pending")
	`PTS_ASSERT_NXT(a_push_moves_pend, cmd.push && cmd_ready && pend_valid_q,
		box_valid && !last_box, "earlier box not moved out on push")
	`PTS_ASSERT_NXT(a_flush_marks_last, cmd.flush && cmd_ready && pend_valid_q,
		box_valid && last_box && !pend_valid_q, "final box of band not marked last")

endmodule
`default_nettype wire

// ----- hw/rtl/pts_ctrl.sv -----
// Pixel and band controller: tracks position and row ink, writes the column ink map
// in RAM, scans and clears it at band end. Depends on pts_pkg and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "projection_text_box_segmenter_macros.svh"
module pts_ctrl #(
	parameter int MAX_WIDTH  = pts_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = pts_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             pixel_valid,
	output logic                                  pixel_ready,
	input  wire logic [23:0]                      pixel_rgb,
	input  wire logic                             first_pixel,
	input  wire logic [pts_pkg::IMG_WIDTH_W-1:0]  image_width,
	input  wire logic [pts_pkg::IMG_HEIGHT_W-1:0] image_height,
	output pts_pkg::box_cmd_t                     cmd,
	input  wire logic                             cmd_ready,
	output logic                                  ram_we,
	output logic      [$clog2(MAX_WIDTH)-1:0]     ram_waddr,
	output logic                                  ram_wdata,
	output logic                                  ram_re,
	output logic      [$clog2(MAX_WIDTH)-1:0]     ram_raddr,
	input  wire logic                             ram_rdata
);
	import pts_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int BOT_W = (ROW_W > BOX_ROW_W) ? ROW_W : BOX_ROW_W;
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_HEIGHT - 1);

	typedef enum logic [2:0] {S_IDLE, S_PIX, S_CLR, S_RD, S_EV, S_END} state_t;

	state_t             state_q;
	logic               ret_idle_q;
	logic               ink_q;
	logic               row_has_ink_q;
	logic               band_open_q;
	logic               dirty_q;
	logic               in_run_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [ROW_W-1:0]   top_q;
	logic [BOX_ROW_W-1:0] bottom_q;
	logic [COL_W-1:0]   idx_q;
	logic [COL_W-1:0]   left_q;

	logic [COL_W-1:0] wlast;
	logic [ROW_W-1:0] hlast;
	logic [COL_W-1:0] col_c;
	logic [ROW_W-1:0] row_c;
	logic             eol;
	logic             last_row;
	logic             rhi;
	logic             open_c;
	logic             close_c;
	logic             in_range;
	logic             found;
	logic             ev_stall;

	always_comb begin
		if (image_width == '0) begin
			wlast = '0;
		end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
			wlast = COL_LAST;
		end else begin
			wlast = COL_W'(image_width - 8'd1);
		end
		if (image_height == '0) begin
			hlast = '0;
		end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
			hlast = ROW_LAST;
		end else begin
			hlast = ROW_W'(image_height - 9'd1);
		end
	end

	assign col_c    = (col_q > wlast) ? wlast : col_q;
	assign row_c    = (row_q > hlast) ? hlast : row_q;
	assign eol      = (col_c == wlast);
	assign last_row = (row_c == hlast);
	assign rhi      = row_has_ink_q || ink_q;
	assign open_c   = rhi && !band_open_q;
	assign close_c  = !rhi && band_open_q;
	assign in_range = (idx_q <= wlast);
	assign found    = (state_q == S_EV) && in_range && !ram_rdata && in_run_q;
	assign ev_stall = found && !cmd_ready;

	assign pixel_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.push       = found;
		cmd.flush      = (state_q == S_END);
		cmd.box.left   = BOX_COL_W'(left_q);
		cmd.box.right  = BOX_COL_W'(idx_q - COL_W'(1));
		cmd.box.top    = BOX_ROW_W'(top_q);
		cmd.box.bottom = bottom_q;
	end

	always_comb begin
		ram_re    = (state_q == S_RD);
		ram_raddr = idx_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = 1'b0;
		unique case (state_q)
			S_PIX: begin
				ram_we    = ink_q;
				ram_waddr = col_c;
				ram_wdata = 1'b1;
			end
			S_CLR: begin
				ram_we = 1'b1;
			end
			S_EV: begin
				ram_we = !ev_stall;
			end
			S_IDLE, S_RD, S_END: begin
				ram_we = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLR;
			ret_idle_q    <= 1'b1;
			ink_q         <= 1'b0;
			row_has_ink_q <= 1'b0;
			band_open_q   <= 1'b0;
			dirty_q       <= 1'b0;
			in_run_q      <= 1'b0;
			col_q         <= '0;
			row_q         <= '0;
			top_q         <= '0;
			bottom_q      <= '0;
			idx_q         <= '0;
			left_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pixel_valid) begin
						ink_q <= (pixel_rgb == 24'd0);
						if (first_pixel) begin
							row_has_ink_q <= 1'b0;
							band_open_q   <= 1'b0;
							col_q         <= '0;
							row_q         <= '0;
						end
						if (first_pixel && dirty_q) begin
							state_q    <= S_CLR;
							ret_idle_q <= 1'b0;
							idx_q      <= '0;
						end else begin
							state_q <= S_PIX;
						end
					end
				end
				S_PIX: begin
					if (ink_q) begin
						dirty_q <= 1'b1;
					end
					if (!eol) begin
						col_q <= col_c + COL_W'(1);
						row_q <= row_c;
						if (ink_q) begin
							row_has_ink_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end else begin
						col_q         <= '0;
						row_has_ink_q <= 1'b0;
						row_q         <= last_row ? '0 : row_c + ROW_W'(1);
						if (close_c) begin
							band_open_q <= 1'b0;
							bottom_q    <= BOX_ROW_W'(BOT_W'(row_c) - BOT_W'(1));
							idx_q       <= '0;
							in_run_q    <= 1'b0;
							state_q     <= S_RD;
						end else if (last_row) begin
							band_open_q <= 1'b0;
							if (dirty_q || ink_q) begin
								state_q    <= S_CLR;
								ret_idle_q <= 1'b1;
								idx_q      <= '0;
							end else begin
								state_q <= S_IDLE;
							end
						end else begin
							if (open_c) begin
								band_open_q <= 1'b1;
								top_q       <= row_c;
							end
							state_q <= S_IDLE;
						end
					end
				end
				S_CLR: begin
					if (idx_q == COL_LAST) begin
						dirty_q <= 1'b0;
						state_q <= ret_idle_q ? S_IDLE : S_PIX;
					end else begin
						idx_q <= idx_q + COL_W'(1);
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (!ev_stall) begin
						if (in_range && ram_rdata && !in_run_q) begin
							in_run_q <= 1'b1;
							left_q   <= idx_q;
						end
						if (found) begin
							in_run_q <= 1'b0;
						end
						if (idx_q == COL_LAST) begin
							state_q <= S_END;
						end else begin
							idx_q   <= idx_q + COL_W'(1);
							state_q <= S_RD;
						end
					end
				end
				S_END: begin
					if (cmd_ready) begin
						dirty_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`PTS_ASSERT_NXT(a_pixel_taken_up, pixel_valid && pixel_ready, state_q != S_IDLE,
		"transfer of a pixel not followed by its update")
	`PTS_ASSERT_IMP(a_box_in_width, cmd.push, in_range && in_run_q,
		"box reported outside the active width")
	`PTS_ASSERT_NXT(a_scan_leaves_clean, cmd.flush && cmd_ready,
		!dirty_q && !band_open_q && pixel_ready, "band scan left map or band set")

endmodule
`default_nettype wire

// ----- hw/rtl/projection_text_box_segmenter.sv -----
// Projection text box segmenter. Takes RGB pixels in raster order (all-zero means
// ink) and reports one box per closed run of ink columns in each text band. A pixel
// is taken in the idle state and then updates position and the column map in the map
// RAM. When a row closes a band, the column map is read and cleared column by column,
// a read state then an evaluate state, over all MAX_WIDTH entries, and the scan holds
// while the box consumer stalls. A clearing pass over all MAX_WIDTH entries follows
// reset, a first_pixel marker while the map holds ink, and an image end while the map
// holds ink; no pixel is taken during a scan or a clearing pass. Boxes leave through a
// one-box output register behind a one-box pending slot, so pixels are taken while a
// box waits. Registers: image_width at byte address 0, image_height at 4. Depends on
// pts_pkg, pts_ram, pts_ctrl and pts_box_out.
`timescale 1ns / 1ps
`default_nettype none
module projection_text_box_segmenter #(
	parameter int MAX_WIDTH  = pts_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = pts_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [pts_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [pts_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [pts_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready,
	input  wire logic                           pixel_valid,
	output logic                                pixel_ready,
	input  wire logic [23:0]                    pixel_rgb,
	input  wire logic                           first_pixel,
	output logic                                box_valid,
	input  wire logic                           box_ready,
	output logic      [pts_pkg::BOX_COL_W-1:0]  box_left,
	output logic      [pts_pkg::BOX_COL_W-1:0]  box_right,
	output logic      [pts_pkg::BOX_ROW_W-1:0]  box_top,
	output logic      [pts_pkg::BOX_ROW_W-1:0]  box_bottom,
	output logic                                last_box
);
	import pts_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic [IMG_WIDTH_W-1:0]  image_width_q;
	logic [IMG_HEIGHT_W-1:0] image_height_q;
	logic                    cfg_wr;

	box_cmd_t         cmd;
	logic             cmd_ready;
	logic             ram_we;
	logic [COL_W-1:0] ram_waddr;
	logic             ram_wdata;
	logic             ram_re;
	logic [COL_W-1:0] ram_raddr;
	logic             ram_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMG_WIDTH_RST;
			image_height_q <= IMG_HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_IMAGE_WIDTH:  image_width_q  <= pwdata[IMG_WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= pwdata[IMG_HEIGHT_W-1:0];
				default:          image_width_q  <= image_width_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width_q);
			REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height_q);
			default:          prdata = '0;
		endcase
	end

	pts_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel_rgb    (pixel_rgb),
		.first_pixel  (first_pixel),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.cmd          (cmd),
		.cmd_ready    (cmd_ready),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	pts_ram #(
		.WIDTH (1),
		.DEPTH (MAX_WIDTH)
	) u_col_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pts_box_out u_box_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cmd_ready  (cmd_ready),
		.box_valid  (box_valid),
		.box_ready  (box_ready),
		.box_left   (box_left),
		.box_right  (box_right),
		.box_top    (box_top),
		.box_bottom (box_bottom),
		.last_box   (last_box)
	);

endmodule
`default_nettype wire
